// ----- hdl/omt_pkg.sv -----
// Package for the order matching table: payload words, cell control and FSM state.
// No dependencies; imported by every module of the block.
package omt_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 128;
  localparam int unsigned KEY_BITS_DEF    = 32;
  localparam int unsigned PRICE_BITS_DEF  = 16;

  // side codes
  localparam logic SIDE_SELL = 1'b0;
  localparam logic SIDE_BUY  = 1'b1;

  typedef struct packed {
    logic [31:0] item_key;
    logic        side;
    logic [15:0] price;
  } omt_in_t;

  typedef struct packed {
    logic        matched;
    logic [15:0] trade_price;
    logic [7:0]  entries_held;
    logic        dropped;
  } omt_out_t;

  // broadcast control to every cell
  typedef struct packed {
    logic capture;    // latch match result for the incoming order
    logic shift_en;   // matched: close the gap behind the hit
    logic append_en;  // unmatched and room left: write order at the tail
  } omt_ctrl_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } omt_state_e;

endpackage

// ----- hdl/omt_cell.sv -----
// One entry of the order table: holds key, side and price, compares against the
// incoming order and takes its neighbour's entry when the row compacts. Uses omt_pkg.
module omt_cell #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned PRICE_BITS = 16,
  parameter int unsigned CW         = 8,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  logic [CW-1:0]         count_i,
  input  omt_pkg::omt_ctrl_t    ctrl_i,
  input  logic                  shift_i,
  input  logic [KEY_BITS-1:0]   cmp_key_i,
  input  logic                  cmp_side_i,
  input  logic [PRICE_BITS-1:0] cmp_price_i,
  input  logic [KEY_BITS-1:0]   wr_key_i,
  input  logic                  wr_side_i,
  input  logic [PRICE_BITS-1:0] wr_price_i,
  input  logic [KEY_BITS-1:0]   nxt_key_i,
  input  logic                  nxt_side_i,
  input  logic [PRICE_BITS-1:0] nxt_price_i,
  output logic [KEY_BITS-1:0]   key_o,
  output logic                  side_o,
  output logic [PRICE_BITS-1:0] price_o,
  output logic                  hit_o
);
  import omt_pkg::*;

  logic [KEY_BITS-1:0]   key_q, key_d;
  logic                  side_q, side_d;
  logic [PRICE_BITS-1:0] price_q, price_d;
  logic                  hit_q, hit_d;
  logic                  occupied, tail, price_ok;

  assign occupied = CW'(IDX) < count_i;
  assign tail     = CW'(IDX) == count_i;
  // seller takes a buyer paying at least its ask; buyer takes a seller at or below its bid
  assign price_ok = (cmp_side_i == SIDE_BUY) ? (cmp_price_i >= price_q)
                                             : (cmp_price_i <= price_q);

  always_comb begin
    hit_d   = hit_q;
    key_d   = key_q;
    side_d  = side_q;
    price_d = price_q;
    if (ctrl_i.capture) begin
      hit_d = occupied && (key_q == cmp_key_i) && (side_q != cmp_side_i) && price_ok;
    end
    if (ctrl_i.shift_en && shift_i) begin
      key_d   = nxt_key_i;
      side_d  = nxt_side_i;
      price_d = nxt_price_i;
    end else if (ctrl_i.append_en && tail) begin
      key_d   = wr_key_i;
      side_d  = wr_side_i;
      price_d = wr_price_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q   <= hit_d;
    key_q   <= key_d;
    side_q  <= side_d;
    price_q <= price_d;
  end

  assign key_o   = key_q;
  assign side_o  = side_q;
  assign price_o = price_q;
  assign hit_o   = hit_q;

endmodule

// ----- hdl/omt_pick.sv -----
// Priority pick over the cell match flags: oldest hit, compaction mask and its price.
// Uses omt_pkg.
module omt_pick #(
  parameter int unsigned TABLE_DEPTH = 128,
  parameter int unsigned PRICE_BITS  = 16
) (
  input  logic [TABLE_DEPTH-1:0] hit_i,
  input  logic [PRICE_BITS-1:0]  price_i [TABLE_DEPTH],
  output logic [TABLE_DEPTH-1:0] shift_o,
  output logic                   found_o,
  output logic [PRICE_BITS-1:0]  price_o
);
  import omt_pkg::*;

  logic [TABLE_DEPTH-1:0] below;   // cells in front of the oldest hit
  logic [TABLE_DEPTH-1:0] onehot;

  // trailing zeros of the hit vector, one subtract
  assign below   = (hit_i - TABLE_DEPTH'(1)) & ~hit_i;
  // lowest set bit only: the oldest hit
  assign onehot  = hit_i & ~(hit_i - TABLE_DEPTH'(1));
  assign shift_o = ~below;
  assign found_o = |hit_i;

  always_comb begin
    price_o = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      price_o = price_o | (price_i[i] & {PRICE_BITS{onehot[i]}});
    end
  end

endmodule

// ----- hdl/order_matching_table.sv -----
// Order matching table, top level. Instantiates a row of omt_cell and one omt_pick;
// types and defaults come from omt_pkg.
//
// Usage
//   Input channel (in_valid_i / in_stall_o / in_word_i): one order per word:
//   item key, side (0 for sale, 1 wanted) and price. Output channel
//   (out_valid_o / out_stall_i / out_word_o): exactly one result word per
//   order: matched flag, trade price (seller's price, 0 if unmatched), entries
//   held afterwards and a dropped flag for an unmatched order met by a full table.
//   The result word is valid from the edge after the one that accepts the
//   order. The block takes no new order until the current one is through:
//   the accept cycle compares the order against every cell at once, the
//   update cycle then picks the oldest hit and compacts the cell row (or
//   appends at the tail) before the next compare.
//   The result sits in an output register; while the receiver stalls it holds
//   its word steady and the block takes no new order.
//   Reset clears the fill count and the control state; cell contents are left
//   as they are and are never read before being written, so no clearing pass.
//   No configuration registers.
module order_matching_table #(
  parameter int unsigned TABLE_DEPTH = omt_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned KEY_BITS    = omt_pkg::KEY_BITS_DEF,
  parameter int unsigned PRICE_BITS  = omt_pkg::PRICE_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  omt_pkg::omt_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output omt_pkg::omt_out_t out_word_o
);
  import omt_pkg::*;

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  // FSM
  omt_state_e state_q, state_d;
  logic       in_accept, updating;

  // order under work, already narrowed to the table widths
  logic [KEY_BITS-1:0]   in_key;
  logic [PRICE_BITS-1:0] in_price;
  logic [KEY_BITS-1:0]   key_q;
  logic                  side_q;
  logic [PRICE_BITS-1:0] price_q;

  logic [CW-1:0] count_q, count_d;

  // cell row
  omt_ctrl_t             ctrl;
  logic [TABLE_DEPTH-1:0] hit_vec, shift_vec;
  logic [KEY_BITS-1:0]   cell_key   [TABLE_DEPTH];
  logic                  cell_side  [TABLE_DEPTH];
  logic [PRICE_BITS-1:0] cell_price [TABLE_DEPTH];

  logic                  found;
  logic [PRICE_BITS-1:0] hit_price;
  logic                  full;

  // result register
  logic     out_valid_q, out_valid_d;
  omt_out_t out_q, out_d;

  assign in_key   = KEY_BITS'(in_word_i.item_key);
  assign in_price = PRICE_BITS'(in_word_i.price);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_accept) state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // FSM outputs; an order is only taken once the result slot is free by
  // the time the update lands
  always_comb begin
    in_stall_o = 1'b1;
    updating   = 1'b0;
    unique case (state_q)
      ST_IDLE:   in_stall_o = out_valid_q && out_stall_i;
      ST_UPDATE: updating = 1'b1;
      default:   in_stall_o = 1'b1;
    endcase
  end

  assign in_accept = in_valid_i && !in_stall_o;
  assign full      = count_q == CW'(TABLE_DEPTH);

  assign ctrl.capture   = in_accept;
  assign ctrl.shift_en  = updating && found;
  assign ctrl.append_en = updating && !found && !full;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]   nxt_key;
    logic                  nxt_side;
    logic [PRICE_BITS-1:0] nxt_price;

    // the last cell has no neighbour behind it; it reloads itself
    if (i == TABLE_DEPTH - 1) begin : g_last
      assign nxt_key   = cell_key[i];
      assign nxt_side  = cell_side[i];
      assign nxt_price = cell_price[i];
    end else begin : g_mid
      assign nxt_key   = cell_key[i+1];
      assign nxt_side  = cell_side[i+1];
      assign nxt_price = cell_price[i+1];
    end

    omt_cell #(
      .KEY_BITS  (KEY_BITS),
      .PRICE_BITS(PRICE_BITS),
      .CW        (CW),
      .IDX       (i)
    ) u_cell (
      .clk_i      (clk_i),
      .count_i    (count_q),
      .ctrl_i     (ctrl),
      .shift_i    (shift_vec[i]),
      .cmp_key_i  (in_key),
      .cmp_side_i (in_word_i.side),
      .cmp_price_i(in_price),
      .wr_key_i   (key_q),
      .wr_side_i  (side_q),
      .wr_price_i (price_q),
      .nxt_key_i  (nxt_key),
      .nxt_side_i (nxt_side),
      .nxt_price_i(nxt_price),
      .key_o      (cell_key[i]),
      .side_o     (cell_side[i]),
      .price_o    (cell_price[i]),
      .hit_o      (hit_vec[i])
    );
  end

  omt_pick #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .PRICE_BITS (PRICE_BITS)
  ) u_pick (
    .hit_i  (hit_vec),
    .price_i(cell_price),
    .shift_o(shift_vec),
    .found_o(found),
    .price_o(hit_price)
  );

  // fill count
  always_comb begin
    count_d = count_q;
    if (ctrl.shift_en) begin
      count_d = count_q - CW'(1);
    end else if (ctrl.append_en) begin
      count_d = count_q + CW'(1);
    end
  end

  // result word; the trade goes at the seller's price
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (updating) begin
      out_valid_d        = 1'b1;
      out_d.matched      = found;
      out_d.trade_price  = '0;
      if (found) begin
        out_d.trade_price = 16'((side_q == SIDE_SELL) ? price_q : hit_price);
      end
      out_d.entries_held = 8'(count_d);
      out_d.dropped      = !found && full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_accept) begin
      key_q   <= in_key;
      side_q  <= in_word_i.side;
      price_q <= in_price;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// ----- hdl/omt_checker.sv -----
// Port-level checks for order_matching_table, attached by the bind at the end.
// Uses omt_pkg for the word types.
module omt_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input omt_pkg::omt_out_t out_word_o
);
  import omt_pkg::*;

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // one order in flight: no accept on the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("order accepted while previous one still in work");

  a_match_not_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_word_o.matched && out_word_o.dropped))
    else $error("matched and dropped together");

  a_no_trade_price: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.matched |-> out_word_o.trade_price == '0)
    else $error("trade price set on an unmatched order");

endmodule

bind order_matching_table omt_checker u_omt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_word_o (out_word_o)
);

// ----- sim/omt_scoreboard_pkg.sv -----
// Scoreboard for the order matching table bench: a predictor of the resting book plus
// an in-order store of awaited result words. Depends on omt_pkg for the word types.
package omt_scoreboard_pkg;
  import omt_pkg::*;

  localparam int unsigned REPORT_LIMIT = 10;

  class omt_match_scoreboard;
    omt_in_t     resting[$];   // resting orders, oldest first
    omt_out_t    awaited[$];   // predicted result words, oldest first
    int unsigned table_depth;
    int unsigned failures;
    int unsigned results_seen;

    function new(int unsigned depth);
      table_depth  = depth;
      failures     = 0;
      results_seen = 0;
    endfunction

    // Run one accepted order against the book and queue the word it should produce.
    function void note_order(omt_in_t ord);
      omt_out_t res;
      int       hit;
      logic     fits;
      res = '0;
      hit = -1;
      foreach (resting[i]) begin
        if (hit < 0 && resting[i].item_key == ord.item_key && resting[i].side != ord.side) begin
          fits = (ord.side == SIDE_SELL) ? (ord.price <= resting[i].price)
                                         : (ord.price >= resting[i].price);
          if (fits) hit = i;
        end
      end
      if (hit >= 0) begin
        res.matched     = 1'b1;
        res.trade_price = (ord.side == SIDE_SELL) ? ord.price : resting[hit].price;
        resting.delete(hit);
      end else if (resting.size() < table_depth) begin
        resting.push_back(ord);
      end else begin
        res.dropped = 1'b1;
      end
      res.entries_held = 8'(resting.size());
      awaited.push_back(res);
    endfunction

    function void flag(string what, int unsigned want, int unsigned got);
      failures++;
      if (failures <= REPORT_LIMIT)
        $display("[%0t] result %0d: %s expected %0h got %0h", $time, results_seen, what,
                 want, got);
    endfunction

    function void check_result(omt_out_t got);
      omt_out_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        flag("word with nothing awaited", 0, got);
        return;
      end
      want = awaited.pop_front();
      if (got.matched !== want.matched) flag("matched", want.matched, got.matched);
      if (got.trade_price !== want.trade_price)
        flag("trade_price", want.trade_price, got.trade_price);
      if (got.entries_held !== want.entries_held)
        flag("entries_held", want.entries_held, got.entries_held);
      if (got.dropped !== want.dropped) flag("dropped", want.dropped, got.dropped);
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction

    function int unsigned held();
      return resting.size();
    endfunction
  endclass

endpackage

// ----- sim/tb.sv -----
// Top-level bench for order_matching_table: directed trades, random order streams with
// bursty sender and stalling receiver, and a table-full episode. Needs omt_pkg, the RTL
// and omt_scoreboard_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import omt_pkg::*;
  import omt_scoreboard_pkg::*;

  localparam int unsigned DEPTH           = TABLE_DEPTH_DEF;
  localparam int unsigned ORDER_TARGET    = 1250;
  localparam int unsigned HOLD_OFF_AT     = 400;   // results seen before the long hold-off
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned IDLE_LIMIT      = 2000;  // cycles with no word moved on either side
  localparam int unsigned KEY_POOL        = 6;
  localparam logic [31:0] FILLER_BASE     = 32'hF11E_0000;

  typedef enum {RX_FLOWING, RX_CHOPPY, RX_CONGESTED} rx_mode_e;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  omt_in_t  in_word;
  logic     out_valid;
  logic     out_stall;
  omt_out_t out_word;

  omt_match_scoreboard sb = new(DEPTH);

  int unsigned orders_sent = 0;
  int unsigned burst_left  = 0;
  int unsigned idle_cycles = 0;
  logic [31:0] key_pool [KEY_POOL];

  order_matching_table dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Both channels are sampled on the edge itself; every driver uses nonblocking
  // assignments, so the values seen here are the ones the block saw.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_order(in_word);
      if (out_valid && !out_stall) sb.check_result(out_word);
    end
  end

  // Watchdog: give up once nothing has moved on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("[order_matching_table] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: wanders between flowing, choppy and congested stretches. Once, after
  // HOLD_OFF_AT results, it holds stall high for a long stretch while the sender keeps
  // offering, so the output register fills and the block stalls its input.
  initial begin
    rx_mode_e    mode;
    int unsigned mode_left;
    logic        hold_off_done;
    mode          = RX_FLOWING;
    mode_left     = 0;
    hold_off_done = 1'b0;
    out_stall <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!hold_off_done && sb.results_seen >= HOLD_OFF_AT) begin
        hold_off_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
          RX_FLOWING: out_stall <= 1'b0;
          RX_CHOPPY:  out_stall <= ($urandom_range(0, 1) == 1);
          default:    out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  function automatic omt_in_t order_of(logic [31:0] key, logic side, logic [15:0] price);
    omt_in_t ord;
    ord.item_key = key;
    ord.side     = side;
    ord.price    = price;
    return ord;
  endfunction

  // Random order: mostly a small key pool with prices clustered so both sides cross
  // often; some pure noise; some extreme prices; and, once the filler block exists,
  // buyers that sweep filler sells out of the middle of the table.
  function automatic omt_in_t random_order(int unsigned filler_keys);
    omt_in_t     ord;
    int unsigned pick;
    pick         = $urandom_range(0, 99);
    ord.side     = 1'($urandom_range(0, 1));
    ord.item_key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    ord.price    = 16'($urandom_range(950, 1050));
    if (pick < 10) begin
      ord.item_key = $urandom;
      ord.price    = 16'($urandom_range(0, 65535));
    end else if (pick < 25 && filler_keys > 0) begin
      ord.item_key = FILLER_BASE + $urandom_range(0, filler_keys - 1);
      ord.side     = SIDE_BUY;
      ord.price    = 16'hFFFF;
    end else if (pick >= 92) begin
      ord.price = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
    end
    return ord;
  endfunction

  // Sender: bursts of random length, random gaps between them (sometimes none, so
  // long back-to-back stretches happen too). The word is held until accepted.
  task automatic send_order(input omt_in_t ord);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= ord;
    orders_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  // Sender pause: stop offering until every awaited word is back, plus the pipeline.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned room;
    logic [31:0] key_lo;
    logic [31:0] key_hi;
    logic [31:0] key_mid;
    key_lo  = 32'h0000_0000;
    key_hi  = 32'hFFFF_FFFF;
    key_mid = 32'h5A5A_A5A5;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    foreach (key_pool[i]) key_pool[i] = $urandom & 32'h7FFF_FFFF;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: price boundaries, equal prices, both sides as aggressor.
    send_order(order_of(key_lo, SIDE_SELL, 16'd100));
    send_order(order_of(key_lo, SIDE_BUY, 16'd99));     // one below ask: rests
    send_order(order_of(key_lo, SIDE_BUY, 16'd100));    // equal price trades
    send_order(order_of(key_lo, SIDE_SELL, 16'd99));    // seller hits resting buyer
    send_order(order_of(key_hi, SIDE_SELL, 16'hFFFF));
    send_order(order_of(key_hi, SIDE_BUY, 16'hFFFF));   // top price
    send_order(order_of(key_hi, SIDE_BUY, 16'h0000));
    send_order(order_of(key_hi, SIDE_SELL, 16'h0000));  // trade at zero, still matched
    // Oldest compatible wins, not the best price; same side never matches.
    send_order(order_of(key_mid, SIDE_SELL, 16'd500));
    send_order(order_of(key_mid, SIDE_SELL, 16'd300));
    send_order(order_of(key_mid, SIDE_SELL, 16'd400));
    send_order(order_of(key_lo, SIDE_BUY, 16'hFFFF));   // other key: no cross
    send_order(order_of(key_mid, SIDE_BUY, 16'd350));   // skips 500, takes 300
    send_order(order_of(key_mid, SIDE_BUY, 16'hFFFF));  // takes 500, the oldest
    send_order(order_of(key_mid, SIDE_SELL, 16'd400));  // sell vs sell: rests
    send_order(order_of(key_lo, SIDE_SELL, 16'h0000));  // trade at seller's zero
    send_order(order_of(key_mid, SIDE_BUY, 16'h0000));
    send_order(order_of(key_mid, SIDE_SELL, 16'h0000)); // buyer at zero behind two sells
    send_order(order_of(key_mid, SIDE_BUY, 16'd400));
    send_order(order_of(key_mid, SIDE_BUY, 16'd399));
    settle();

    repeat (500) send_order(random_order(0));
    settle();

    // Table-full episode: top the book up with unique-key sells, then a few more that
    // must be dropped with the table unchanged.
    room = DEPTH - sb.held();
    for (int unsigned i = 0; i < room + 6; i++)
      send_order(order_of(FILLER_BASE + i, SIDE_SELL, 16'($urandom_range(0, 65535))));

    while (orders_sent < ORDER_TARGET) send_order(random_order(room));
    settle();

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[order_matching_table] OK");
    end else begin
      $display("[order_matching_table] ERROR");
    end
    $finish;
  end

endmodule
